// ===== hw/rtl/md_pkg.sv =====
package md_pkg;

	localparam int HEADER_BYTES = 4;
	localparam int LEN_W        = 32;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] MODE_RAW   = 2'd0;
	localparam logic [1:0] MODE_LEN   = 2'd1;
	localparam logic [1:0] MODE_DELIM = 2'd2;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic [1:0] DELIM_FULL = 2'd3;

	typedef struct packed {
		logic [1:0] rel_cnt;
		logic       item_vld;
		logic [7:0] data;
		logic       has_byte;
		logic       last;
	} md_cmd_t;

	function automatic logic [7:0] delim_byte(input logic [1:0] idx);
		logic [7:0] res;
		unique case (idx)
			2'd0: res = CHAR_CR;
			2'd1: res = CHAR_LF;
			2'd2: res = CHAR_CR;
			default: res = CHAR_LF;
		endcase
		return res;
	endfunction

endpackage

// ===== hw/rtl/md_rx_if.sv =====
interface md_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/md_cfg_if.sv =====
interface md_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] framing_mode;

	modport source(output valid, output framing_mode, input ready);
	modport sink(input valid, input framing_mode, output ready);
endinterface

// ===== hw/rtl/md_msg_if.sv =====
interface md_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       has_byte;
	logic       msg_last;

	modport source(output valid, output msg_byte, output has_byte, output msg_last,
		input ready);
	modport sink(input valid, input msg_byte, input has_byte, input msg_last,
		output ready);
endinterface

// ===== hw/rtl/message_deframer.sv =====
// Splits a received byte stream into messages.
// The rx channel takes one byte per request; the msg channel gives one result
// per request: a payload byte, or a bare end marker with has_byte low.
// The cfg channel writes framing_mode: 0 and 3 pass bytes through, 1 reads a
// four-byte little-endian length then forwards that many bytes, and 2 cuts
// messages at CR LF CR LF. Every write clears the framing state and must only
// come while the block is idle.
// The front classifies each byte in the cycle it is taken and, where it yields
// output, places a command in a four-entry queue; the back expands each command
// into one to four results, one per cycle while the receiver is ready, through
// a registered output stage.
// Throughput is one byte per cycle while the queue is not full; a byte that
// releases held delimiter bytes takes the back one result at a time, which the queue absorbs.
// Reset clears the mode to passthrough and empties the queue.
// When the receiver stalls, the output register holds, the queue fills and
// rx.ready drops once the queue holds four commands.
module message_deframer (
	input  logic     clk,
	input  logic     arst_n,
	md_cfg_if.sink   cfg,
	md_rx_if.sink    rx,
	md_msg_if.source msg
);
	import md_pkg::*;

	logic    q_push;
	logic    q_full;
	logic    q_pop;
	logic    q_empty;
	md_cmd_t push_cmd;
	md_cmd_t head_cmd;

	md_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx     (rx),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (push_cmd)
	);

	md_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.empty    (q_empty)
	);

	md_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.pop      (q_pop),
		.msg      (msg)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full)) else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("queue read while empty");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		msg.valid && !msg.has_byte |-> msg.msg_last && msg.msg_byte == 8'h00)
		else $error("bare end marker malformed");
endmodule

// ===== hw/rtl/md_front.sv =====
module md_front (
	input  logic            clk,
	input  logic            arst_n,
	md_cfg_if.sink          cfg,
	md_rx_if.sink           rx,
	input  logic            q_full,
	output logic            q_push,
	output md_pkg::md_cmd_t q_cmd
);
	import md_pkg::*;

	logic [1:0]       mode_q;
	logic             in_payload_q;
	logic [1:0]       hdr_cnt_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] remain_q;
	logic [1:0]       match_q;

	logic             accept;
	logic [LEN_W-1:0] len_next;
	logic             hdr_done;
	md_cmd_t          cmd;

	assign cfg.ready = 1'b1;
	assign rx.ready  = !q_full;
	assign accept    = rx.valid && rx.ready;
	assign hdr_done  = (hdr_cnt_q == 2'(HEADER_BYTES - 1));

	always_comb begin
		len_next = len_q;
		unique case (hdr_cnt_q)
			2'd0: len_next[7:0]   = len_q[7:0]   | rx.rx_byte;
			2'd1: len_next[15:8]  = len_q[15:8]  | rx.rx_byte;
			2'd2: len_next[23:16] = len_q[23:16] | rx.rx_byte;
			default: len_next[31:24] = len_q[31:24] | rx.rx_byte;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (mode_q)
			MODE_LEN: begin
				if (!in_payload_q) begin
					if (hdr_done && len_next == '0) begin
						cmd.item_vld = 1'b1;
						cmd.last     = 1'b1;
					end
				end else begin
					cmd.item_vld = 1'b1;
					cmd.data     = rx.rx_byte;
					cmd.has_byte = 1'b1;
					cmd.last     = (remain_q == LEN_W'(1));
				end
			end
			MODE_DELIM: begin
				if (rx.rx_byte == delim_byte(match_q)) begin
					if (match_q == DELIM_FULL) begin
						cmd.item_vld = 1'b1;
						cmd.last     = 1'b1;
					end
				end else begin
					cmd.rel_cnt = match_q;
					if (rx.rx_byte != CHAR_CR) begin
						cmd.item_vld = 1'b1;
						cmd.data     = rx.rx_byte;
						cmd.has_byte = 1'b1;
					end
				end
			end
			default: begin
				cmd.item_vld = 1'b1;
				cmd.data     = rx.rx_byte;
				cmd.has_byte = 1'b1;
			end
		endcase
	end

	assign q_cmd  = cmd;
	assign q_push = accept && (cmd.item_vld || cmd.rel_cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_RAW;
			in_payload_q <= 1'b0;
			hdr_cnt_q    <= '0;
			len_q        <= '0;
			remain_q     <= '0;
			match_q      <= '0;
		end else if (cfg.valid) begin
			mode_q       <= cfg.framing_mode;
			in_payload_q <= 1'b0;
			hdr_cnt_q    <= '0;
			len_q        <= '0;
			remain_q     <= '0;
			match_q      <= '0;
		end else if (accept) begin
			unique case (mode_q)
				MODE_LEN: begin
					if (!in_payload_q) begin
						if (hdr_done) begin
							hdr_cnt_q <= '0;
							len_q     <= '0;
							if (len_next != '0) begin
								in_payload_q <= 1'b1;
								remain_q     <= len_next;
							end
						end else begin
							hdr_cnt_q <= hdr_cnt_q + 2'd1;
							len_q     <= len_next;
						end
					end else begin
						remain_q <= remain_q - LEN_W'(1);
						if (remain_q == LEN_W'(1)) begin
							in_payload_q <= 1'b0;
						end
					end
				end
				MODE_DELIM: begin
					if (rx.rx_byte == delim_byte(match_q)) begin
						if (match_q == DELIM_FULL) begin
							match_q <= '0;
						end else begin
							match_q <= match_q + 2'd1;
						end
					end else if (rx.rx_byte == CHAR_CR) begin
						match_q <= 2'd1;
					end else begin
						match_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

// ===== hw/rtl/md_queue.sv =====
module md_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  md_pkg::md_cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output md_pkg::md_cmd_t head_cmd,
	output logic            empty
);
	import md_pkg::*;

	md_cmd_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end
endmodule

// ===== hw/rtl/md_back.sv =====
module md_back (
	input  logic            clk,
	input  logic            arst_n,
	input  md_pkg::md_cmd_t head_cmd,
	input  logic            empty,
	output logic            pop,
	md_msg_if.source        msg
);
	import md_pkg::*;

	logic [1:0] idx_q;
	logic       out_vld_q;
	logic [7:0] out_byte_q;
	logic       out_has_q;
	logic       out_last_q;

	logic       load;
	logic       in_release;
	logic       final_res;
	logic [7:0] res_byte;
	logic       res_has;
	logic       res_last;

	assign load       = !empty && (!out_vld_q || msg.ready);
	assign in_release = (idx_q < head_cmd.rel_cnt);

	always_comb begin
		if (in_release) begin
			res_byte  = delim_byte(idx_q);
			res_has   = 1'b1;
			res_last  = 1'b0;
			final_res = (idx_q + 2'd1 == head_cmd.rel_cnt) && !head_cmd.item_vld;
		end else begin
			res_byte  = head_cmd.data;
			res_has   = head_cmd.has_byte;
			res_last  = head_cmd.last;
			final_res = 1'b1;
		end
	end

	assign pop = load && final_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
				idx_q     <= final_res ? 2'd0 : idx_q + 2'd1;
			end else if (msg.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= res_byte;
			out_has_q  <= res_has;
			out_last_q <= res_last;
		end
	end

	assign msg.valid    = out_vld_q;
	assign msg.msg_byte = out_byte_q;
	assign msg.has_byte = out_has_q;
	assign msg.msg_last = out_last_q;
endmodule
